[hw/rtl/otlw_pkg.sv]
package otlw_pkg;

   // Display geometry and text limits.
   localparam int PAGE_COUNT   = 8;
   localparam int COLUMN_COUNT = 128;
   localparam int COLUMN_LIMIT = 122;

   // Request codes.
   typedef enum logic [1:0] {
      OP_INIT  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_LINE  = 2'd2,
      OP_CHAR  = 2'd3
   } opcode_type;

   // Jobs handed from the front end to the byte sequencer.
   typedef enum logic [1:0] {
      JOB_INIT,
      JOB_CLEAR,
      JOB_LINE,
      JOB_CHAR
   } job_kind_type;

   localparam int SETUP_LEN    = 25;
   localparam int GLYPH_COUNT  = 42;
   localparam int GLYPH_COLS   = 5;
   localparam int CHAR_STEPS   = GLYPH_COLS + 1;
   localparam int PAGE_STEPS   = 4;
   localparam int CLEAR_STEPS  = PAGE_COUNT * PAGE_STEPS;
   localparam int LINE_STEPS   = 7;
   localparam int GLYPH_W      = $clog2(GLYPH_COUNT);
   localparam int GCOL_W       = $clog2(GLYPH_COLS);
   localparam int STEP_W       = $clog2((CLEAR_STEPS > SETUP_LEN) ? CLEAR_STEPS : SETUP_LEN);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] PAGE_CMD    = 8'hB0;
   localparam logic [7:0] COL_LO_CMD  = 8'h00;
   localparam logic [7:0] COL_HI_CMD  = 8'h10;
   localparam logic [7:0] BLANK_BYTE  = 8'h00;
   localparam logic [7:0] CHAR_ADVANCE = 8'd6;

   // Glyph indexes of the digit and letter bases, the punctuation entries, the space and the fallback.
   localparam logic [GLYPH_W-1:0] GLYPH_DIGIT0   = GLYPH_W'(0);
   localparam logic [GLYPH_W-1:0] GLYPH_LETTERA  = GLYPH_W'(10);
   localparam logic [GLYPH_W-1:0] GLYPH_COLON    = GLYPH_W'(36);
   localparam logic [GLYPH_W-1:0] GLYPH_PERIOD   = GLYPH_W'(37);
   localparam logic [GLYPH_W-1:0] GLYPH_DASH     = GLYPH_W'(38);
   localparam logic [GLYPH_W-1:0] GLYPH_SLASH    = GLYPH_W'(39);
   localparam logic [GLYPH_W-1:0] GLYPH_SPACE    = GLYPH_W'(40);
   localparam logic [GLYPH_W-1:0] GLYPH_FALLBACK = GLYPH_W'(41);

   typedef struct packed {
      job_kind_type       kind;
      logic [2:0]         row;
      logic [GLYPH_W-1:0] glyph;
   } job_type;

   // One run of equal bytes on its way to the merger.
   typedef struct packed {
      logic       is_data;
      logic [7:0] byte_value;
      logic [7:0] count;
      logic       last;
   } elem_type;

   localparam logic [7:0] SETUP_SEQ [SETUP_LEN] = '{
      8'hAE, 8'hD5, 8'h80, 8'hA8, 8'h3F, 8'hD3, 8'h00, 8'h40, 8'h8D, 8'h14, 8'h20, 8'h02,
      8'hA1, 8'hC8, 8'hDA, 8'h12, 8'h81, 8'hCF, 8'hD9, 8'hF1, 8'hDB, 8'h40, 8'hA4, 8'hA6,
      8'hAF};

   localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_COLS] = '{
      '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
      '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
      '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
      '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
      '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
      '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
      '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
      '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
      '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
      '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
      '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
      '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
      '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
      '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
      '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
      '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
      '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
      '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
      '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00}, '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00},
      '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08}, '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, '{8'h02, 8'h01, 8'h51, 8'h09, 8'h06}};

   // Maps a character code to its glyph; lowercase shares the uppercase glyph.
   function automatic logic [GLYPH_W-1:0] glyph_index(input logic [7:0] code);
      logic [7:0]         folded;
      logic [GLYPH_W-1:0] idx;
      folded = (code >= 8'h61 && code <= 8'h7A) ? code - 8'd32 : code;
      priority if (folded >= 8'h30 && folded <= 8'h39) begin
         idx = GLYPH_DIGIT0 + GLYPH_W'(folded - 8'h30);
      end else if (folded >= 8'h41 && folded <= 8'h5A) begin
         idx = GLYPH_LETTERA + GLYPH_W'(folded - 8'h41);
      end else if (folded == 8'h3A) begin
         idx = GLYPH_COLON;
      end else if (folded == 8'h2E) begin
         idx = GLYPH_PERIOD;
      end else if (folded == 8'h2D) begin
         idx = GLYPH_DASH;
      end else if (folded == 8'h2F) begin
         idx = GLYPH_SLASH;
      end else if (folded == 8'h20) begin
         idx = GLYPH_SPACE;
      end else begin
         idx = GLYPH_FALLBACK;
      end
      return idx;
   endfunction

endpackage

[hw/rtl/oled_text_line_writer_top.sv]
// Text line writer for a page-addressed monochrome display controller.
// The request channel takes an opcode (init, clear, begin line, character), a row
// and a character code. The response channel returns controller bytes, each with a
// command/data flag, a repeat count for runs of equal bytes, and a flag on the
// final response of its request. Requests that produce nothing send no response.
// The front end decides what a request does and updates the column and the open
// line at once, so requests are accepted while earlier ones are still being sent;
// a four-entry job queue separates it from the byte sequencer.
// The sequencer produces one byte run per cycle while the merge stage takes runs:
// a character is 6 runs, a begin line 7, a clear 32 and an init 25. When the block
// is idle, the first response of a request goes through the queue, the sequencer's
// job register, the merge accumulator and the output register, and waits longer
// when its first bytes repeat and merge into one run. Response stalls back up
// through the merge stage into the sequencer and then the queue; the request side
// stalls only while the queue is full. Synchronous reset empties the queue and the
// output register, sets the column to zero and closes the line.
module oled_text_line_writer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [3:0] req_row,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_data,
   output logic [7:0] rsp_byte_value,
   output logic [7:0] rsp_repeat_count,
   output logic       rsp_last
);

   logic                queue_full;
   logic                queue_not_empty;
   logic                push;
   logic                pop;
   otlw_pkg::job_type   push_job;
   otlw_pkg::job_type   queue_head;
   logic                elem_valid;
   logic                elem_take;
   otlw_pkg::elem_type  elem;

   otlw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_row       (req_row),
      .req_char_code (req_char_code),
      .queue_full    (queue_full),
      .push          (push),
      .push_job      (push_job)
   );

   otlw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   otlw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_head      (queue_head),
      .pop             (pop),
      .elem_valid      (elem_valid),
      .elem            (elem),
      .elem_take       (elem_take)
   );

   otlw_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .elem_valid       (elem_valid),
      .elem             (elem),
      .elem_take        (elem_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_data      (rsp_is_data),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_last         (rsp_last)
   );

endmodule

[hw/rtl/otlw_front.sv]
module otlw_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_opcode,
   input  logic [3:0]           req_row,
   input  logic [7:0]           req_char_code,
   input  logic                 queue_full,
   output logic                 push,
   output otlw_pkg::job_type    push_job
);

   logic [7:0] column_pos_ff, column_pos_in;
   logic       line_active_ff, line_active_in;
   logic       accept;
   logic       has_job;
   logic [8:0] column_sum;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept && has_job;
   assign column_sum = {1'b0, column_pos_ff} + {1'b0, otlw_pkg::CHAR_ADVANCE};

   always_comb begin
      has_job        = 1'b0;
      column_pos_in  = column_pos_ff;
      line_active_in = line_active_ff;
      push_job.kind  = otlw_pkg::JOB_CHAR;
      push_job.row   = req_row[2:0];
      push_job.glyph = otlw_pkg::glyph_index(req_char_code);
      if (accept) begin
         unique case (otlw_pkg::opcode_type'(req_opcode))
            otlw_pkg::OP_INIT: begin
               has_job        = 1'b1;
               push_job.kind  = otlw_pkg::JOB_INIT;
               line_active_in = 1'b0;
            end
            otlw_pkg::OP_CLEAR: begin
               has_job        = 1'b1;
               push_job.kind  = otlw_pkg::JOB_CLEAR;
               line_active_in = 1'b0;
            end
            otlw_pkg::OP_LINE: begin
               if ({1'b0, req_row} < 5'(otlw_pkg::PAGE_COUNT)) begin
                  has_job        = 1'b1;
                  push_job.kind  = otlw_pkg::JOB_LINE;
                  column_pos_in  = '0;
                  line_active_in = 1'b1;
               end else begin
                  line_active_in = 1'b0;
               end
            end
            otlw_pkg::OP_CHAR: begin
               if (line_active_ff) begin
                  if (req_char_code == 8'd0) begin
                     line_active_in = 1'b0;
                  end else if (column_pos_ff <= 8'(otlw_pkg::COLUMN_LIMIT)) begin
                     has_job       = 1'b1;
                     push_job.kind = otlw_pkg::JOB_CHAR;
                     column_pos_in = column_sum[8] ? 8'hFF : column_sum[7:0];
                  end
               end
            end
            default: begin
               has_job = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_pos_ff  <= '0;
         line_active_ff <= 1'b0;
      end else begin
         column_pos_ff  <= column_pos_in;
         line_active_ff <= line_active_in;
      end
   end

endmodule

[hw/rtl/otlw_queue.sv]
module otlw_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  otlw_pkg::job_type    push_job,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output otlw_pkg::job_type    head
);

   otlw_pkg::job_type                  entries_ff [otlw_pkg::QUEUE_DEPTH];
   logic [otlw_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [otlw_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [otlw_pkg::QPTR_W:0]          count_ff, count_in;

   assign full      = (count_ff == (otlw_pkg::QPTR_W + 1)'(otlw_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + otlw_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + otlw_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (otlw_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (otlw_pkg::QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hw/rtl/otlw_back.sv]
module otlw_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_not_empty,
   input  otlw_pkg::job_type    queue_head,
   output logic                 pop,
   output logic                 elem_valid,
   output otlw_pkg::elem_type   elem,
   input  logic                 elem_take
);

   otlw_pkg::job_type             cur_ff, cur_in;
   logic                          busy_ff, busy_in;
   logic [otlw_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [otlw_pkg::STEP_W-1:0]   last_step;
   logic                          at_last;
   logic                          done;
   logic [2:0]                    clear_page;

   assign elem_valid = busy_ff;
   assign at_last    = (step_ff == last_step);
   assign done       = elem_take && at_last;
   assign pop        = queue_not_empty && (!busy_ff || done);
   assign clear_page = 3'(step_ff >> 2);

   always_comb begin
      unique case (cur_ff.kind)
         otlw_pkg::JOB_INIT:  last_step = otlw_pkg::STEP_W'(otlw_pkg::SETUP_LEN - 1);
         otlw_pkg::JOB_CLEAR: last_step = otlw_pkg::STEP_W'(otlw_pkg::CLEAR_STEPS - 1);
         otlw_pkg::JOB_LINE:  last_step = otlw_pkg::STEP_W'(otlw_pkg::LINE_STEPS - 1);
         otlw_pkg::JOB_CHAR:  last_step = otlw_pkg::STEP_W'(otlw_pkg::CHAR_STEPS - 1);
         default:             last_step = '0;
      endcase
   end

   // Byte of the current step; the blank run of a page travels as one element.
   always_comb begin
      elem.is_data    = 1'b0;
      elem.byte_value = otlw_pkg::BLANK_BYTE;
      elem.count      = 8'd1;
      elem.last       = at_last;
      unique case (cur_ff.kind)
         otlw_pkg::JOB_INIT: begin
            elem.byte_value = otlw_pkg::SETUP_SEQ[step_ff];
         end
         otlw_pkg::JOB_CLEAR: begin
            unique case (step_ff[1:0])
               2'd0: elem.byte_value = otlw_pkg::PAGE_CMD | {5'd0, clear_page};
               2'd1: elem.byte_value = otlw_pkg::COL_LO_CMD;
               2'd2: elem.byte_value = otlw_pkg::COL_HI_CMD;
               default: begin
                  elem.is_data = 1'b1;
                  elem.count   = 8'(otlw_pkg::COLUMN_COUNT);
               end
            endcase
         end
         otlw_pkg::JOB_LINE: begin
            unique case (step_ff[2:0])
               3'd0, 3'd4: elem.byte_value = otlw_pkg::PAGE_CMD | {5'd0, cur_ff.row};
               3'd1, 3'd5: elem.byte_value = otlw_pkg::COL_LO_CMD;
               3'd2, 3'd6: elem.byte_value = otlw_pkg::COL_HI_CMD;
               3'd3: begin
                  elem.is_data = 1'b1;
                  elem.count   = 8'(otlw_pkg::COLUMN_COUNT);
               end
               default: elem.byte_value = otlw_pkg::COL_LO_CMD;
            endcase
         end
         otlw_pkg::JOB_CHAR: begin
            elem.is_data = 1'b1;
            if (step_ff < otlw_pkg::STEP_W'(otlw_pkg::GLYPH_COLS)) begin
               elem.byte_value =
                  otlw_pkg::GLYPH_ROM[cur_ff.glyph][step_ff[otlw_pkg::GCOL_W-1:0]];
            end
         end
         default: begin
            elem.is_data = 1'b0;
         end
      endcase
   end

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      if (pop) begin
         cur_in  = queue_head;
         busy_in = 1'b1;
         step_in = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (elem_take) begin
         step_in = step_ff + otlw_pkg::STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

endmodule

[hw/rtl/otlw_merge.sv]
module otlw_merge (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 elem_valid,
   input  otlw_pkg::elem_type   elem,
   output logic                 elem_take,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_is_data,
   output logic [7:0]           rsp_byte_value,
   output logic [7:0]           rsp_repeat_count,
   output logic                 rsp_last
);

   otlw_pkg::elem_type acc_ff, acc_in;
   logic               acc_valid_ff, acc_valid_in;
   otlw_pkg::elem_type out_ff, out_in;
   logic               out_valid_ff, out_valid_in;
   logic [8:0]         count_sum;
   logic               same;
   logic               out_free;
   logic               flush;

   assign count_sum = {1'b0, acc_ff.count} + {1'b0, elem.count};
   assign out_free  = !out_valid_ff || !rsp_stall;

   // An element extends the pending run when it repeats the same byte of the same
   // request and the count still fits.
   assign same = acc_valid_ff && !acc_ff.last && elem_valid &&
                 (acc_ff.is_data == elem.is_data) &&
                 (acc_ff.byte_value == elem.byte_value) && !count_sum[8];

   assign flush     = acc_valid_ff && (acc_ff.last || (elem_valid && !same)) && out_free;
   assign elem_take = elem_valid && (!acc_valid_ff || same || flush);

   always_comb begin
      acc_in       = acc_ff;
      acc_valid_in = acc_valid_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (flush) begin
         out_in       = acc_ff;
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (elem_take) begin
         if (same) begin
            acc_in.count = count_sum[7:0];
            acc_in.last  = elem.last;
         end else begin
            acc_in       = elem;
            acc_valid_in = 1'b1;
         end
      end else if (flush) begin
         acc_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      out_ff <= out_in;
      if (reset) begin
         acc_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_valid_ff <= acc_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_is_data      = out_ff.is_data;
   assign rsp_byte_value   = out_ff.byte_value;
   assign rsp_repeat_count = out_ff.count;
   assign rsp_last         = out_ff.last;

endmodule

[hw/rtl/otlw_checker.sv]
module otlw_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_is_data,
   input logic [7:0] rsp_byte_value,
   input logic [7:0] rsp_repeat_count,
   input logic       rsp_last
);

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_is_data) && $stable(rsp_byte_value) &&
                                 $stable(rsp_repeat_count) && $stable(rsp_last))
      else $error("response changed while stalled");

   // Command bytes never repeat back to back.
   a_cmd_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_data |-> rsp_repeat_count == 8'd1)
      else $error("command byte with a repeat count");

   // Data runs are at most one page wide.
   a_data_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_data |-> rsp_repeat_count != 8'd0 &&
                                   rsp_repeat_count <= 8'd128)
      else $error("data run length out of range");

   // The first cycle after reset shows no response.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

endmodule

bind oled_text_line_writer_top otlw_checker u_otlw_checker (.*);
